// ===== sv/fifo_vertex_cache_miss_counter_macros.svh =====
// ----------------------------------------------------------------------------
// FIFO vertex cache miss counter assertion macros
// Concurrent assertion helpers shared by the RTL modules of the block.
// ----------------------------------------------------------------------------
`ifndef FIFO_VERTEX_CACHE_MISS_COUNTER_MACROS_SVH
`define FIFO_VERTEX_CACHE_MISS_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is held.
`define FVCMC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that is checked at every clock edge, reset included.
`define FVCMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FVCMC_ASSERT(lbl, clk, rst, prop, msg)
`define FVCMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/fvcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO vertex cache miss counter package
// Sizes, transaction types, controller commands and a helper function.
// ----------------------------------------------------------------------------
package fvcmc_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int PTR_W       = $clog2(MAX_ENTRIES);
  localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
  localparam int OFF_W       = PTR_W + 1;
  localparam int CFG_W       = 6;
  localparam int CAP_W       = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int VI_W        = 32;
  localparam int COUNT_W     = 32;

  localparam logic [CFG_W-1:0] CACHE_ENTRIES_RESET = CFG_W'(32);

  typedef struct packed {
    logic [VI_W-1:0] vertex_index;
    logic            end_of_mesh;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] index_count;
    logic [COUNT_W-1:0] miss_count;
    logic               last_of_mesh;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic compare;
    logic update;
  } fvcmc_cmd_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== sv/fifo_vertex_cache_miss_counter.sv =====
// ----------------------------------------------------------------------------
// FIFO vertex cache miss counter
// Simulates a FIFO post-transform vertex cache over a stream of vertex
// indices and reports hits with running per-mesh index and miss counts.
// ----------------------------------------------------------------------------
// A transaction goes from acceptance to the result register in order: the
// index is captured, all cache slots are compared against it in parallel and
// the match vector is registered, and the matches are reduced and the ring,
// counters and result are updated, which waits while the output is stalled.
// A new transaction is accepted while an earlier result still waits to be
// taken. The user must write the capacity register only while idle, and the
// block does not enforce it; values above the ring size use the whole ring.
module fifo_vertex_cache_miss_counter import fvcmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  fvcmc_cmd_t cmd;

  fvcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fvcmc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

// ===== sv/fvcmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIFO vertex cache miss counter controller
// Sequences capture, compare and update of one transaction and owns the
// output valid flag.
// ----------------------------------------------------------------------------
`include "fifo_vertex_cache_miss_counter_macros.svh"

module fvcmc_ctrl import fvcmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output fvcmc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);
  assign cmd.load_in = (state == S_IDLE) && in_valid;
  assign cmd.compare = (state == S_CMP);
  assign cmd.update  = (state == S_UPD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FVCMC_ASSERT(a_accept_to_cmp, clk, rst, (in_valid && !in_stall) |=> (state == S_CMP), "accepted transaction did not enter compare")
  `FVCMC_ASSERT(a_cmp_to_upd, clk, rst, (state == S_CMP) |=> (state == S_UPD), "compare was not followed by update")
  `FVCMC_ASSERT(a_result_from_upd, clk, rst, $rose(out_valid) |-> ($past(state) == S_UPD), "result appeared without an update")

endmodule

// ===== sv/fvcmc_datapath.sv =====
// ----------------------------------------------------------------------------
// FIFO vertex cache miss counter datapath
// Holds the cache ring, occupancy, mesh counters, capacity register and the
// output register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
`include "fifo_vertex_cache_miss_counter_macros.svh"

module fvcmc_datapath import fvcmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  fvcmc_cmd_t       cmd,
  input  in_t              in_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output out_t             out_data
);

  logic [CFG_W-1:0]       cache_entries;
  logic [VI_W-1:0]        slots [MAX_ENTRIES];
  logic [FILL_W-1:0]      slots_filled;
  logic [FILL_W-1:0]      slots_filled_next;
  logic [PTR_W-1:0]       oldest_pointer;
  logic [PTR_W-1:0]       oldest_pointer_next;
  logic [COUNT_W-1:0]     indices_seen;
  logic [COUNT_W-1:0]     misses_seen;
  logic [COUNT_W-1:0]     indices_next;
  logic [COUNT_W-1:0]     misses_next;
  in_t                    item;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] match;
  logic                   hit;
  logic [CAP_W-1:0]       cap;
  logic                   has_room;
  logic [OFF_W-1:0]       wpos_sum;
  logic [PTR_W-1:0]       wpos;

  // A slot is occupied when its distance from the oldest entry is below the fill.
  always_comb begin
    logic [OFF_W-1:0] off;
    for (int p = 0; p < MAX_ENTRIES; p++) begin
      if (OFF_W'(p) >= OFF_W'(oldest_pointer)) begin
        off = OFF_W'(p) - OFF_W'(oldest_pointer);
      end else begin
        off = OFF_W'(p) + OFF_W'(MAX_ENTRIES) - OFF_W'(oldest_pointer);
      end
      match_vec[p] = (off < OFF_W'(slots_filled)) && (slots[p] == item.vertex_index);
    end
  end

  assign hit = |match;
  assign cap = (CAP_W'(cache_entries) > CAP_W'(MAX_ENTRIES)) ?
               CAP_W'(MAX_ENTRIES) : CAP_W'(cache_entries);
  assign has_room = CAP_W'(slots_filled) < cap;
  assign wpos_sum = OFF_W'(oldest_pointer) + OFF_W'(slots_filled);
  assign wpos = (wpos_sum >= OFF_W'(MAX_ENTRIES)) ?
                PTR_W'(wpos_sum - OFF_W'(MAX_ENTRIES)) : PTR_W'(wpos_sum);

  always_comb begin
    slots_filled_next   = slots_filled;
    oldest_pointer_next = oldest_pointer;
    indices_next        = sat_inc(indices_seen);
    misses_next         = misses_seen;
    if (!hit) begin
      misses_next = sat_inc(misses_seen);
      if (has_room) begin
        slots_filled_next = slots_filled + FILL_W'(1);
      end else if (oldest_pointer == PTR_W'(MAX_ENTRIES - 1)) begin
        oldest_pointer_next = '0;
      end else begin
        oldest_pointer_next = oldest_pointer + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_entries  <= CACHE_ENTRIES_RESET;
      slots_filled   <= '0;
      oldest_pointer <= '0;
      indices_seen   <= '0;
      misses_seen    <= '0;
    end else begin
      if (cfg_wr_en) begin
        cache_entries <= cfg_wr_data;
      end
      if (cmd.update) begin
        if (item.end_of_mesh) begin
          slots_filled   <= '0;
          oldest_pointer <= '0;
          indices_seen   <= '0;
          misses_seen    <= '0;
        end else begin
          slots_filled   <= slots_filled_next;
          oldest_pointer <= oldest_pointer_next;
          indices_seen   <= indices_next;
          misses_seen    <= misses_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_data;
    end
    if (cmd.compare) begin
      match <= match_vec;
    end
    if (cmd.update) begin
      if (!hit) begin
        slots[wpos] <= item.vertex_index;
      end
      out_data.hit          <= hit;
      out_data.index_count  <= indices_next;
      out_data.miss_count   <= misses_next;
      out_data.last_of_mesh <= item.end_of_mesh;
    end
  end

  `FVCMC_ASSERT(a_fill_bound, clk, rst, slots_filled <= FILL_W'(MAX_ENTRIES), "cache fill exceeds the number of slots")
  `FVCMC_ASSERT(a_ptr_bound, clk, rst, OFF_W'(oldest_pointer) < OFF_W'(MAX_ENTRIES), "oldest pointer outside the ring")
  `FVCMC_ASSERT(a_mesh_clear, clk, rst, (cmd.update && item.end_of_mesh) |=> (indices_seen == '0 && misses_seen == '0 && slots_filled == '0), "mesh state not cleared after the last transaction")

endmodule
